/* hdl/lfu_pkg.sv */
package lfu_pkg;

	// Geometry
	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 16;
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W     = $clog2(CAPACITY + 1);

	// Fixed field widths
	localparam int KEY_PORT_W = 16;
	localparam int DATA_W     = 32;
	localparam int CNT_W      = 16;
	localparam int CAP_REG_W  = 5;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [DATA_W-1:0] MISS_VALUE = '1;

	typedef enum logic [1:0] {
		CMD_TOUCH  = 2'b01,
		CMD_INSERT = 2'b10
	} cmd_kind_t;

	// Search record that walks the cell row, one cell per cycle
	typedef struct packed {
		logic                 pv;
		logic [KEY_WIDTH-1:0] key;
		logic                 hit;
		logic [IDX_W-1:0]     hit_idx;
		logic [DATA_W-1:0]    hit_data;
		logic [IDX_W-1:0]     hit_rank;
		logic                 vic_v;
		logic [IDX_W-1:0]     vic_idx;
		logic [CNT_W-1:0]     vic_cnt;
		logic [IDX_W-1:0]     vic_rank;
		logic [KEY_WIDTH-1:0] vic_key;
		logic                 free_v;
		logic [IDX_W-1:0]     free_idx;
	} probe_t;

	// Update broadcast to every cell
	typedef struct packed {
		logic                 en;
		cmd_kind_t            kind;
		logic [IDX_W-1:0]     idx;
		logic [IDX_W-1:0]     rank;
		logic                 wr_data;
		logic [DATA_W-1:0]    data;
		logic [KEY_WIDTH-1:0] key;
		logic                 ev;
		logic [IDX_W-1:0]     vic_idx;
		logic [IDX_W-1:0]     vic_rank;
		logic [IDX_W-1:0]     ins_idx;
	} cmd_t;

endpackage

/* hdl/lfu_ifs.sv */
interface lfu_req_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   operation;
	logic [lfu_pkg::KEY_PORT_W-1:0]         key;
	logic signed [lfu_pkg::DATA_W-1:0]      write_value;

	modport source(output valid, operation, key, write_value, input ready);
	modport sink(input valid, operation, key, write_value, output ready);
endinterface

interface lfu_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   found;
	logic signed [lfu_pkg::DATA_W-1:0]      read_value;
	logic                                   evicted;
	logic [lfu_pkg::KEY_PORT_W-1:0]         evicted_key;

	modport source(output valid, found, read_value, evicted, evicted_key, input ready);
	modport sink(input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [lfu_pkg::CAP_REG_W-1:0]          capacity_in_use;

	modport source(output valid, capacity_in_use, input ready);
	modport sink(input valid, capacity_in_use, output ready);
endinterface

/* hdl/lfu_cache_lookup_insert_unit.sv */
// Channel   Dir  Payload                                          Handshake
// req       in   operation, key, write_value                      valid/ready
// rsp       out  found, read_value, evicted, evicted_key          valid/ready
// cfg       in   capacity_in_use                                  valid/ready, ready tied high
//
// A transaction runs from accept to the next accept through these steps: accept, the walk
// of the search record through the cell row, capture of the finished record, and the
// broadcast of the update.
// The cell row is the limit: each cell adds one register stage to the search.
// A new request is taken once the previous update has been broadcast, even while
// its result still waits in the output register; a stalled rsp holds the update.
// arst_n clears all slot valid bits, the occupancy and the FSM; capacity goes to 16.
module lfu_cache_lookup_insert_unit (
	input  logic          clk,
	input  logic          arst_n,
	lfu_req_if.sink       req,
	lfu_rsp_if.source     rsp,
	lfu_cfg_if.sink       cfg
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t                              state_q;
	logic                                launch_q;
	logic                                op_q;
	logic [lfu_pkg::KEY_WIDTH-1:0]       key_q;
	logic [lfu_pkg::DATA_W-1:0]          wval_q;
	logic [lfu_pkg::CAP_REG_W-1:0]       cap_q;
	logic [lfu_pkg::OCC_W-1:0]           occ_q;
	lfu_pkg::probe_t                     res_q;

	logic                                out_valid_q;
	logic                                found_q;
	logic [lfu_pkg::DATA_W-1:0]          rval_q;
	logic                                evicted_q;
	logic [lfu_pkg::KEY_PORT_W-1:0]      evkey_q;

	lfu_pkg::probe_t                     link [lfu_pkg::CAPACITY+1];
	lfu_pkg::cmd_t                       cmd;

	logic                                in_acc;
	logic                                out_free;
	logic                                upd_fire;
	logic [31:0]                         limit;
	logic                                need_ev;

	// --- handshakes ---
	assign in_acc    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;
	assign upd_fire  = (state_q == S_UPD) && out_free;

	// --- configuration ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CAP_REG_W'(lfu_pkg::CAPACITY);
		end else if (cfg.valid && cfg.ready) begin
			cap_q <= cfg.capacity_in_use;
		end
	end

	// Clamp the capacity register into 1 .. CAPACITY
	always_comb begin
		if (cap_q == '0) begin
			limit = 32'd1;
		end else if (32'(cap_q) > 32'(lfu_pkg::CAPACITY)) begin
			limit = 32'(lfu_pkg::CAPACITY);
		end else begin
			limit = 32'(cap_q);
		end
	end

	assign need_ev = (32'(occ_q) >= limit);

	// --- cell row: the search record enters cell 0 once per transaction ---
	always_comb begin
		link[0]          = '0;
		link[0].pv       = launch_q;
		link[0].key      = key_q;
	end

	for (genvar i = 0; i < lfu_pkg::CAPACITY; i++) begin : g_cell
		lfu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (lfu_pkg::IDX_W'(i)),
			.probe_in  (link[i]),
			.probe_out (link[i+1]),
			.cmd       (cmd)
		);
	end

	// --- request capture and FSM ---
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= req.operation;
			key_q  <= req.key[lfu_pkg::KEY_WIDTH-1:0];
			wval_q <= req.write_value;
		end
		// hold the finished search until the update is broadcast
		if (state_q == S_SCAN && link[lfu_pkg::CAPACITY].pv) begin
			res_q <= link[lfu_pkg::CAPACITY];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
			occ_q    <= '0;
		end else begin
			launch_q <= in_acc;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (link[lfu_pkg::CAPACITY].pv) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (out_free) begin
						state_q <= S_IDLE;
						// a new key grows occupancy unless it replaced a victim
						if (!res_q.hit && op_q == lfu_pkg::OP_PUT && !need_ev) begin
							occ_q <= occ_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// --- update broadcast and result ---
	always_comb begin
		cmd         = '0;
		cmd.kind    = lfu_pkg::CMD_TOUCH;
		cmd.idx     = res_q.hit_idx;
		cmd.rank    = res_q.hit_rank;
		cmd.wr_data = (op_q == lfu_pkg::OP_PUT);
		cmd.data    = wval_q;
		cmd.key     = key_q;
		cmd.vic_idx = res_q.vic_idx;
		cmd.vic_rank = res_q.vic_rank;
		cmd.ev      = need_ev;
		// insert into the lowest free slot, counting the victim's slot as free
		if (need_ev && !(res_q.free_v && res_q.free_idx < res_q.vic_idx)) begin
			cmd.ins_idx = res_q.vic_idx;
		end else begin
			cmd.ins_idx = res_q.free_idx;
		end
		if (res_q.hit) begin
			cmd.en   = upd_fire;
		end else if (op_q == lfu_pkg::OP_PUT) begin
			cmd.en   = upd_fire;
			cmd.kind = lfu_pkg::CMD_INSERT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			found_q   <= res_q.hit;
			evicted_q <= 1'b0;
			evkey_q   <= '0;
			if (op_q == lfu_pkg::OP_PUT) begin
				rval_q <= '0;
				if (!res_q.hit && need_ev) begin
					evicted_q <= 1'b1;
					evkey_q   <= lfu_pkg::KEY_PORT_W'(res_q.vic_key);
				end
			end else if (res_q.hit) begin
				rval_q <= res_q.hit_data;
			end else begin
				rval_q <= lfu_pkg::MISS_VALUE;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.read_value  = rval_q;
	assign rsp.evicted     = evicted_q;
	assign rsp.evicted_key = evkey_q;

	// --- assertions ---
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(lfu_pkg::CAPACITY))
		else $error("occupancy above capacity");

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		link[lfu_pkg::CAPACITY].pv |-> state_q == S_SCAN)
		else $error("search record left the row outside a scan");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_SCAN && launch_q))
		else $error("accepted transaction did not launch a search");

	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && !res_q.hit && op_q == lfu_pkg::OP_PUT && !need_ev) |-> res_q.free_v)
		else $error("insert without eviction found no free slot");

	a_evict_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && !res_q.hit && op_q == lfu_pkg::OP_PUT && need_ev) |-> res_q.vic_v)
		else $error("eviction without a victim");

endmodule

/* hdl/lfu_cell.sv */
module lfu_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lfu_pkg::IDX_W-1:0]      cell_idx,
	input  lfu_pkg::probe_t                probe_in,
	output lfu_pkg::probe_t                probe_out,
	input  lfu_pkg::cmd_t                  cmd
);

	logic                                  valid_q;
	logic [lfu_pkg::KEY_WIDTH-1:0]         key_q;
	logic [lfu_pkg::DATA_W-1:0]            data_q;
	logic [lfu_pkg::CNT_W-1:0]             cnt_q;
	logic [lfu_pkg::IDX_W-1:0]             rank_q;
	lfu_pkg::probe_t                       probe_nxt;
	lfu_pkg::probe_t                       probe_q;

	// Fold this slot into the passing search record
	always_comb begin
		probe_nxt = probe_in;
		if (valid_q && key_q == probe_in.key && !probe_in.hit) begin
			probe_nxt.hit      = 1'b1;
			probe_nxt.hit_idx  = cell_idx;
			probe_nxt.hit_data = data_q;
			probe_nxt.hit_rank = rank_q;
		end
		if (valid_q && (!probe_in.vic_v || cnt_q < probe_in.vic_cnt ||
		    (cnt_q == probe_in.vic_cnt && rank_q > probe_in.vic_rank))) begin
			probe_nxt.vic_v    = 1'b1;
			probe_nxt.vic_idx  = cell_idx;
			probe_nxt.vic_cnt  = cnt_q;
			probe_nxt.vic_rank = rank_q;
			probe_nxt.vic_key  = key_q;
		end
		if (!valid_q && !probe_in.free_v) begin
			probe_nxt.free_v   = 1'b1;
			probe_nxt.free_idx = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_nxt;
		end
	end

	assign probe_out = probe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.en && cmd.kind == lfu_pkg::CMD_INSERT) begin
			if (cell_idx == cmd.ins_idx) begin
				valid_q <= 1'b1;
			end else if (cmd.ev && cell_idx == cmd.vic_idx) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			unique case (cmd.kind)
				lfu_pkg::CMD_TOUCH: begin
					if (cell_idx == cmd.idx) begin
						rank_q <= '0;
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (cmd.wr_data) begin
							data_q <= cmd.data;
						end
					end else if (valid_q && rank_q < cmd.rank) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				lfu_pkg::CMD_INSERT: begin
					if (cell_idx == cmd.ins_idx) begin
						key_q  <= cmd.key;
						data_q <= cmd.data;
						cnt_q  <= lfu_pkg::CNT_W'(1);
						rank_q <= '0;
					end else if (valid_q && !(cmd.ev && cell_idx == cmd.vic_idx)) begin
						// older than the victim: shift down by eviction, up by insert
						if (!(cmd.ev && rank_q > cmd.vic_rank)) begin
							rank_q <= rank_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
